FILE: hdl/multichannel_sine_window_gate_assert.svh
// assertion macros used by the checker file msg_checker
`ifndef MULTICHANNEL_SINE_WINDOW_GATE_ASSERT_SVH
`define MULTICHANNEL_SINE_WINDOW_GATE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MSG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MSG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/msg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_pkg
// types, constants and the half-sine table of the sine window gate
// ----------------------------------------------------------------------------
package msg_pkg;

   localparam logic       CSR_CHANNEL_COUNT = 1'b0;
   localparam logic       CSR_INDEX_MODE    = 1'b1;
   localparam logic [15:0] SPREAD_MIN       = 16'd26;
   localparam logic [12:0] ONE_Q12          = 13'd4096;
   localparam int unsigned OUT_LIMIT        = 64;
   localparam int unsigned DIV_STAGES       = 7;

   localparam logic [14:0] SINE_Q [0:32] = '{
      15'd0,     15'd1608,  15'd3212,  15'd4808,  15'd6393,  15'd7962,  15'd9512,
      15'd11039, 15'd12539, 15'd14010, 15'd15446, 15'd16846, 15'd18204, 15'd19519,
      15'd20787, 15'd22005, 15'd23170, 15'd24279, 15'd25329, 15'd26319, 15'd27245,
      15'd28105, 15'd28898, 15'd29621, 15'd30273, 15'd30852, 15'd31356, 15'd31785,
      15'd32137, 15'd32412, 15'd32609, 15'd32728, 15'd32767
   };

   typedef struct packed {
      logic signed [15:0] smp;
      logic [21:0]        rem;
      logic [20:0]        wide;
      logic [13:0]        quo;
      logic               inwin;
      logic [5:0]         chan;
      logic               last;
   } chan_type;

   // half-sine point i of a 65-point table
   function automatic logic [14:0] half_sine(input logic [6:0] i);
      logic [6:0] k;
      logic [5:0] q;
      begin
         k = (i > 7'd64) ? 7'd64 : i;
         q = (k <= 7'd32) ? k[5:0] : 6'(7'd64 - k);
         half_sine = SINE_Q[q];
      end
   endfunction

endpackage

FILE: hdl/msg_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_gain
// per-channel pipeline: window phase divide, sine interpolation, product
// ----------------------------------------------------------------------------
module msg_gain (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  msg_pkg::chan_type in_item,
   output logic              out_valid,
   output logic signed [31:0] out_prod,
   output logic [5:0]        out_chan,
   output logic              out_last
);
   import msg_pkg::*;

   chan_type          dv_ff [0:DIV_STAGES-1];
   logic              dvv_ff [0:DIV_STAGES-1];
   logic signed [15:0] g_smp_ff;
   logic [15:0]       g_gain_ff;
   logic [5:0]        g_chan_ff;
   logic              g_last_ff, g_valid_ff;
   logic signed [31:0] p_prod_ff;
   logic [5:0]        p_chan_ff;
   logic              p_last_ff, p_valid_ff;
   logic [15:0]       gain_in;

   // one restoring quotient bit
   function automatic chan_type div_step(input chan_type c);
      chan_type   r;
      logic [21:0] t;
      begin
         r = c;
         t = {c.rem[20:0], 1'b0};
         if (t >= {1'b0, c.wide}) begin
            r.rem = t - {1'b0, c.wide};
            r.quo = {c.quo[12:0], 1'b1};
         end else begin
            r.rem = t;
            r.quo = {c.quo[12:0], 1'b0};
         end
         div_step = r;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= div_step(div_step(in_item));
         for (int s = 1; s < DIV_STAGES; s++) begin
            dv_ff[s] <= div_step(div_step(dv_ff[s-1]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) dvv_ff[s] <= 1'b0;
         g_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else if (en) begin
         dvv_ff[0] <= in_valid;
         for (int s = 1; s < DIV_STAGES; s++) dvv_ff[s] <= dvv_ff[s-1];
         g_valid_ff <= dvv_ff[DIV_STAGES-1];
         p_valid_ff <= g_valid_ff;
      end
   end

   // linear interpolation between two table points
   always_comb begin
      logic [13:0]        ph;
      logic [15:0]        g0, g1;
      logic signed [16:0] dg;
      logic signed [26:0] acc;
      ph = dv_ff[DIV_STAGES-1].quo;
      g0 = {1'b0, half_sine({1'b0, ph[13:8]})};
      g1 = {1'b0, half_sine(7'({1'b0, ph[13:8]} + 7'd1))};
      dg = $signed({1'b0, g1}) - $signed({1'b0, g0});
      acc = $signed({3'b0, g0, 8'b0}) + dg * $signed({1'b0, ph[7:0]});
      gain_in = dv_ff[DIV_STAGES-1].inwin ? 16'(acc >>> 8) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_smp_ff  <= dv_ff[DIV_STAGES-1].smp;
         g_gain_ff <= gain_in;
         g_chan_ff <= dv_ff[DIV_STAGES-1].chan;
         g_last_ff <= dv_ff[DIV_STAGES-1].last;
         p_prod_ff <= g_smp_ff * $signed({1'b0, g_gain_ff});
         p_chan_ff <= g_chan_ff;
         p_last_ff <= g_last_ff;
      end
   end

   assign out_valid = p_valid_ff;
   assign out_prod  = p_prod_ff;
   assign out_chan  = p_chan_ff;
   assign out_last  = p_last_ff;

endmodule

FILE: hdl/multichannel_sine_window_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_sine_window_gate
// spreads each sample over a ring of channels with a half-sine window
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req_    | in  | tdata: sample[15:0], position[39:16], spread[55:40]
//  rsp_    | out | tdata: gated_sample; tuser: channel; tlast: last channel
//  csr_    | in  | we, index (0 channel_count, 1 index_mode), wdata
//
//  one response beat per cycle unless the output stalls; channel_count beats
//  per request beat, channel_count clamped to 2..MAX_CHANNELS and at most 64;
//  stage 4 loads the next request in the cycle its predecessor issues its last
//  channel, and three front stages buffer requests ahead of it
//  first response path: stages 1-4, divider stages, gain, product, output register
//  rsp_tready low with a beat waiting stalls the pipeline, nothing is dropped
//  synchronous reset: channel_count = 2, index_mode = 0, pipeline empty
module multichannel_sine_window_gate #(
   parameter int unsigned MAX_CHANNELS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // sample, position, spread
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // gated_sample
   output logic [5:0]  rsp_tuser,   // channel
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);
   import msg_pkg::*;

   localparam int unsigned CAP_RAW = (MAX_CHANNELS < OUT_LIMIT) ? MAX_CHANNELS : OUT_LIMIT;
   localparam logic [6:0]  CAP = 7'((CAP_RAW < 2) ? 2 : CAP_RAW);

   // configuration
   logic [6:0] cc_ff;
   logic       im_ff;
   logic [6:0] n;

   // front stages
   logic               f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;
   logic signed [15:0] f1_smp_ff, f2_smp_ff, f3_smp_ff, f4_smp_ff;
   logic signed [23:0] f1_pos_ff;
   logic [15:0]        f1_spr_ff, f2_sc_ff;
   logic signed [31:0] f2_pos_ff;
   logic [20:0]        f3_posc_ff, f3_wide_ff, f4_wide_ff;
   logic [17:0]        f4_m_ff;
   logic [5:0]         f4_j_ff;
   logic               f1_ready, f2_ready, f3_ready, f4_ready, f4_take, f4_last;
   logic               advance;
   logic [18:0]        span;
   logic [17:0]        m0_in, m_next_in;

   // channel pipe and output register
   chan_type           issue;
   logic               gp_valid, gp_last;
   logic signed [31:0] gp_prod;
   logic [5:0]         gp_chan;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_data_ff;
   logic [5:0]         rsp_chan_ff;
   logic               rsp_last_ff;
   logic signed [31:0] rnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= 7'd2;
         im_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: cc_ff <= csr_wdata;
            CSR_INDEX_MODE:    im_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign n    = (cc_ff < 7'd2) ? 7'd2 : ((cc_ff > CAP) ? CAP : cc_ff);
   assign span = {n[6:0], 12'b0};

   // whole pipeline moves unless a finished beat is stuck at the output
   assign advance  = !rsp_valid_ff || rsp_tready;
   assign f4_last  = (f4_j_ff == 6'(n - 7'd1));
   assign f4_take  = advance && f4_valid_ff && f4_last;
   assign f4_ready = !f4_valid_ff || f4_take;
   assign f3_ready = !f3_valid_ff || f4_ready;
   assign f2_ready = !f2_valid_ff || f3_ready;
   assign f1_ready = !f1_valid_ff || f2_ready;
   assign req_tready = f1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else begin
         if (f1_ready) f1_valid_ff <= req_tvalid;
         if (f2_ready) f2_valid_ff <= f1_valid_ff;
         if (f3_ready) f3_valid_ff <= f2_valid_ff;
         if (f4_ready) f4_valid_ff <= f3_valid_ff;
      end
   end

   // stage 1: capture beat
   always_ff @(posedge clock) begin
      if (f1_ready) begin
         f1_smp_ff <= req_tdata[15:0];
         f1_pos_ff <= req_tdata[39:16];
         f1_spr_ff <= req_tdata[55:40];
      end
   end

   // stage 2: spread floor, position scaling
   always_ff @(posedge clock) begin
      if (f2_ready) begin
         f2_smp_ff <= f1_smp_ff;
         f2_sc_ff  <= (f1_spr_ff < SPREAD_MIN) ? SPREAD_MIN : f1_spr_ff;
         f2_pos_ff <= im_ff ? 32'(f1_pos_ff) : 32'(f1_pos_ff) * $signed({25'b0, n});
      end
   end

   // stage 3: clamp to the ring, center the window
   always_ff @(posedge clock) begin
      logic [18:0] clamped;
      if (f2_pos_ff < 0)                         clamped = 19'd0;
      else if (f2_pos_ff > $signed({13'b0, span})) clamped = span;
      else                                       clamped = f2_pos_ff[18:0];
      if (f3_ready) begin
         f3_smp_ff  <= f2_smp_ff;
         f3_posc_ff <= 21'(clamped) + 21'({f2_sc_ff, 4'b0});
         f3_wide_ff <= {f2_sc_ff, 5'b0};
      end
   end

   // whole channels of the centered position, reduced modulo n
   always_comb begin
      logic [6:0] r;
      logic [8:0] hi;
      hi = f3_posc_ff[20:12];
      r  = 7'd0;
      for (int i = 8; i >= 0; i--) begin
         r = {r[5:0], hi[i]};
         if (r >= n) r = r - n;
      end
      m0_in = {r[5:0], f3_posc_ff[11:0]};
   end

   // step one channel back around the ring
   assign m_next_in = (f4_m_ff >= 18'(ONE_Q12)) ? (f4_m_ff - 18'(ONE_Q12))
                    : 18'({1'b0, f4_m_ff} + span - 19'(ONE_Q12));

   // stage 4: channel sequencer
   always_ff @(posedge clock) begin
      if (f4_ready) begin
         f4_smp_ff  <= f3_smp_ff;
         f4_wide_ff <= f3_wide_ff;
         f4_m_ff    <= m0_in;
         f4_j_ff    <= 6'd0;
      end else if (advance && f4_valid_ff) begin
         f4_m_ff <= m_next_in;
         f4_j_ff <= f4_j_ff + 6'd1;
      end
   end

   always_comb begin
      issue.smp   = f4_smp_ff;
      issue.rem   = {4'b0, f4_m_ff};
      issue.wide  = f4_wide_ff;
      issue.quo   = 14'd0;
      issue.inwin = ({3'b0, f4_m_ff} < f4_wide_ff);
      issue.chan  = f4_j_ff;
      issue.last  = f4_last;
   end

   msg_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (f4_valid_ff),
      .in_item   (issue),
      .out_valid (gp_valid),
      .out_prod  (gp_prod),
      .out_chan  (gp_chan),
      .out_last  (gp_last)
   );

   // round to nearest, ties toward plus infinity
   assign rnd = gp_prod + 32'sd16384;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= gp_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rnd[30:15];
         rsp_chan_ff <= gp_chan;
         rsp_last_ff <= gp_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/msg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msg_checker
// port-level checks of the sine window gate, bound to the top level
// ----------------------------------------------------------------------------
`include "multichannel_sine_window_gate_assert.svh"

module msg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [5:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic [22:0] rsp_beat;

   assign rsp_beat = {rsp_tdata, rsp_tuser, rsp_tlast};

   // stalled beat stays
   `MSG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // stalled payload stays
   `MSG_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_beat))
   // pipeline comes out of reset empty
   `MSG_ASSERT_IMP(a_rsp_reset, clock, reset, $past(reset), !rsp_tvalid)
   // at least two channels, so the last never is channel zero
   `MSG_ASSERT_IMP(a_last_chan, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser != 6'd0)

endmodule

bind multichannel_sine_window_gate msg_checker u_msg_checker (.*);
